@@ rtl/assert_macros.svh @@
// Assertion helpers for clocked properties on clk with rst_n low as reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLY(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/aopi_pkg.sv @@
`default_nettype none

package aopi_pkg;

    localparam int CNT_W            = 32;
    localparam int HEAD_W           = 16;
    localparam int POS_W            = 48;
    localparam int SCALE_W          = 24;
    localparam int THR_W            = 15;
    localparam int CFG_W            = 24;
    localparam int IDX_W            = 2;
    localparam int INCH_W           = 48;
    localparam int V_W              = 53;
    localparam int Z_W              = 34;
    localparam int STEP_W           = 5;
    localparam int OPND_W           = 33;
    localparam int PROD_W           = 66;
    localparam int DIV_STEPS        = 31;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic [31:0] GAIN_Q30 = 32'd652032874;
    localparam logic [31:0] PI_Q30   = 32'd3373259426;
    localparam logic [31:0] ONE_Q30  = 32'd1073741824;

    localparam logic [SCALE_W-1:0] DRIVE_RST  = 24'd400000;
    localparam logic [SCALE_W-1:0] BACK_RST   = 24'd2952;
    localparam logic [THR_W-1:0]   THRESH_RST = 15'd182;

    typedef enum logic [IDX_W-1:0] {
        REG_DRIVE  = 2'd0,
        REG_BACK   = 2'd1,
        REG_THRESH = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic signed [CNT_W-1:0] right_count;
        logic signed [CNT_W-1:0] left_count;
        logic signed [CNT_W-1:0] back_count;
        logic [HEAD_W-1:0]       heading;
    } aopi_in_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x_pos;
        logic signed [POS_W-1:0] y_pos;
    } aopi_out_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_R,
        ST_MUL_L,
        ST_MUL_B,
        ST_DEC,
        ST_ROT_INIT,
        ST_ROT_STEP,
        ST_Q_ABS,
        ST_Q_HI,
        ST_Q_LO,
        ST_Q_END,
        ST_H_MUL,
        ST_H_END,
        ST_DIV_INIT,
        ST_DIV_STEP,
        ST_K,
        ST_ACC
    } state_t;

    // which job the shared rotator and Q30 multiplier work on
    typedef enum logic [2:0] {
        PH_ARC,
        PH_KB,
        PH_KR,
        PH_FIN_X,
        PH_FIN_Y
    } phase_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_R,
        OP_MUL_L,
        OP_MUL_B,
        OP_DEC,
        OP_ROT_INIT,
        OP_ROT_STEP,
        OP_Q_ABS,
        OP_Q_HI,
        OP_Q_LO,
        OP_Q_END,
        OP_H_MUL,
        OP_H_END,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_K,
        OP_ACC
    } op_t;

    typedef struct packed {
        op_t               op;
        phase_t            phase;
        logic [STEP_W-1:0] step;
    } aopi_cmd_t;

    typedef struct packed {
        logic turn;
    } aopi_stat_t;

    // arctangent of 2^-i, 2^32 units per turn
    function automatic logic [31:0] atan_lut(input logic [STEP_W-1:0] idx);
        logic [31:0] a;
        case (idx)
            5'd0:    a = 32'h20000000;
            5'd1:    a = 32'h12E4051E;
            5'd2:    a = 32'h09FB385B;
            5'd3:    a = 32'h051111D4;
            5'd4:    a = 32'h028B0D43;
            5'd5:    a = 32'h0145D7E1;
            5'd6:    a = 32'h00A2F61E;
            5'd7:    a = 32'h00517C55;
            5'd8:    a = 32'h0028BE53;
            5'd9:    a = 32'h00145F2F;
            5'd10:   a = 32'h000A2F98;
            5'd11:   a = 32'h000517CC;
            5'd12:   a = 32'h00028BE6;
            5'd13:   a = 32'h000145F3;
            5'd14:   a = 32'h0000A2FA;
            5'd15:   a = 32'h0000517D;
            5'd16:   a = 32'h000028BE;
            5'd17:   a = 32'h0000145F;
            5'd18:   a = 32'h00000A30;
            5'd19:   a = 32'h00000518;
            5'd20:   a = 32'h0000028C;
            5'd21:   a = 32'h00000146;
            5'd22:   a = 32'h000000A3;
            5'd23:   a = 32'h00000051;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

@@ rtl/aopi_datapath.sv @@
`default_nettype none

module aopi_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [aopi_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [aopi_pkg::CFG_W-1:0]    cfg_data,
    input  wire aopi_pkg::aopi_in_t            in_data,
    input  wire aopi_pkg::aopi_cmd_t           cmd,
    output aopi_pkg::aopi_stat_t               stat,
    output aopi_pkg::aopi_out_t                out_data
);
    import aopi_pkg::*;

    // configuration
    logic [SCALE_W-1:0] drive_reg;
    logic [SCALE_W-1:0] back_reg;
    logic [THR_W-1:0]   thr_reg;

    // sample history and pose
    logic [CNT_W-1:0]        last_right_reg, last_left_reg, last_back_reg;
    logic [HEAD_W-1:0]       last_heading_reg;
    logic signed [POS_W-1:0] x_accum_reg, y_accum_reg;

    // working registers
    logic signed [CNT_W-1:0]  d_right_reg, d_left_reg, d_back_reg;
    logic [HEAD_W-1:0]        mag_reg;
    logic [31:0]              mid_reg;
    logic                     turn_reg;
    logic signed [INCH_W-1:0] right_in_reg, left_in_reg, back_in_reg;
    logic signed [PROD_W-1:0] p_reg;
    logic signed [V_W-1:0]    cx_reg, cy_reg;
    logic signed [Z_W-1:0]    cz_reg;
    logic [V_W-2:0]           qm_reg;
    logic                     qneg_reg;
    logic [55:0]              qhi_reg;
    logic [31:0]              s_reg, h_reg, k_reg;
    logic [31:0]              rem_reg;
    logic [DIV_STEPS-1:0]     num_reg, quo_reg;
    logic                     sat_reg;
    logic signed [V_W-1:0]    lx_reg, ly_reg;

    // combinational values
    logic [HEAD_W-1:0]        dh;
    logic [HEAD_W-1:0]        mag;
    logic [31:0]              mid_turn;
    logic signed [OPND_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] inch_sum;
    logic signed [INCH_W-1:0] inch;
    logic signed [V_W-1:0]    q_src;
    logic [31:0]              q_const;
    logic [V_W-1:0]           q_abs;
    logic [PROD_W-1:0]        qlo_sum;
    logic [55:0]              q_mag;
    logic [V_W-1:0]           q_res;
    logic signed [V_W-1:0]    rx, ry;
    logic signed [Z_W-1:0]    rz;
    logic signed [V_W-1:0]    sx, sy;
    logic signed [Z_W-1:0]    atan_z;
    logic [PROD_W-1:0]        h_sum;
    logic [62:0]              div_num;
    logic [32:0]              div_trial;
    logic signed [53:0]       acc_x_next, acc_y_next;

    function automatic logic [POS_W-1:0] sat48(input logic signed [53:0] v);
        logic [POS_W-1:0] r;
        if (v > 54'sd140737488355327) begin
            r = {1'b0, {(POS_W-1){1'b1}}};
        end else if (v < -54'sd140737488355328) begin
            r = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    // heading delta, its magnitude and the mid-arc angle
    assign dh       = in_data.heading - last_heading_reg;
    assign mag      = dh[HEAD_W-1] ? (16'd0 - dh) : dh;
    assign mid_turn = {in_data.heading, 16'd0} - ({{16{dh[HEAD_W-1]}}, dh} << 15);

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MUL_R:
            begin
                mul_a = {d_right_reg[CNT_W-1], d_right_reg};
                mul_b = {9'd0, drive_reg};
            end
            OP_MUL_L:
            begin
                mul_a = {d_left_reg[CNT_W-1], d_left_reg};
                mul_b = {9'd0, drive_reg};
            end
            OP_MUL_B:
            begin
                mul_a = {d_back_reg[CNT_W-1], d_back_reg};
                mul_b = {9'd0, back_reg};
            end
            OP_Q_HI:
            begin
                mul_a = {11'd0, qm_reg[51:30]};
                mul_b = {1'b0, q_const};
            end
            OP_Q_LO:
            begin
                mul_a = {3'd0, qm_reg[29:0]};
                mul_b = {1'b0, q_const};
            end
            OP_H_MUL:
            begin
                mul_a = {17'd0, mag_reg};
                mul_b = {1'b0, PI_Q30};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // ticks times scale, rounded half up to Q16 inches
    assign inch_sum = p_reg + 66'sd128;
    assign inch     = inch_sum[55:8];

    // Q30 product source and factor
    always_comb
    begin
        case (cmd.phase)
            PH_ARC:   q_src = cy_reg;
            PH_KB:    q_src = {{(V_W-INCH_W){back_in_reg[INCH_W-1]}}, back_in_reg};
            PH_KR:    q_src = {{(V_W-INCH_W){right_in_reg[INCH_W-1]}}, right_in_reg};
            PH_FIN_X: q_src = cx_reg;
            PH_FIN_Y: q_src = cy_reg;
            default:  q_src = '0;
        endcase
        if (cmd.phase == PH_KB || cmd.phase == PH_KR) begin
            q_const = k_reg;
        end else begin
            q_const = GAIN_Q30;
        end
    end

    assign q_abs   = q_src[V_W-1] ? -q_src : q_src;
    assign qlo_sum = p_reg + 66'd536870912;
    assign q_mag   = qhi_reg + 56'(qlo_sum[65:30]);
    assign q_res   = qneg_reg ? (53'd0 - q_mag[V_W-1:0]) : q_mag[V_W-1:0];

    // rotator load with quadrant fold
    always_comb
    begin
        if (cmd.phase == PH_ARC) begin
            rx = 53'sd1073741824;
            ry = '0;
            rz = {3'd0, mag_reg, 15'd0};
        end else begin
            rx = ly_reg;
            ry = lx_reg;
            rz = {{2{mid_reg[31]}}, mid_reg};
        end
        if (rz > 34'sd1073741824) begin
            rx = -rx;
            ry = -ry;
            rz = rz - 34'sd2147483648;
        end else if (rz < -34'sd1073741824) begin
            rx = -rx;
            ry = -ry;
            rz = rz + 34'sd2147483648;
        end
    end

    assign sx     = cx_reg >>> cmd.step;
    assign sy     = cy_reg >>> cmd.step;
    assign atan_z = {2'd0, atan_lut(cmd.step)};

    // arc length h, dividend and one restoring division step
    assign h_sum     = p_reg + 66'd32768;
    assign div_num   = {1'b0, s_reg, 30'd0} + {32'd0, h_reg[31:1]};
    assign div_trial = {rem_reg, num_reg[DIV_STEPS-1]};

    assign acc_x_next = $signed({{6{x_accum_reg[POS_W-1]}}, x_accum_reg})
                      + $signed({lx_reg[V_W-1], lx_reg});
    assign acc_y_next = $signed({{6{y_accum_reg[POS_W-1]}}, y_accum_reg})
                      + $signed({ly_reg[V_W-1], ly_reg});

    // write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            drive_reg <= DRIVE_RST;
            back_reg  <= BACK_RST;
            thr_reg   <= THRESH_RST;
        end else if (cfg_we) begin
            unique case (reg_idx_t'(cfg_index))
                REG_DRIVE:  drive_reg <= cfg_data[SCALE_W-1:0];
                REG_BACK:   back_reg  <= cfg_data[SCALE_W-1:0];
                REG_THRESH: thr_reg   <= cfg_data[THR_W-1:0];
                default:    ;
            endcase
        end
    end

    // hold history and advance the pose
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            last_right_reg   <= '0;
            last_left_reg    <= '0;
            last_back_reg    <= '0;
            last_heading_reg <= '0;
            x_accum_reg      <= '0;
            y_accum_reg      <= '0;
        end else if (cmd.op == OP_LOAD) begin
            last_right_reg   <= in_data.right_count;
            last_left_reg    <= in_data.left_count;
            last_back_reg    <= in_data.back_count;
            last_heading_reg <= in_data.heading;
        end else if (cmd.op == OP_ACC) begin
            x_accum_reg <= sat48(acc_x_next);
            y_accum_reg <= sat48(acc_y_next);
        end
    end

    // datapath working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                d_right_reg <= in_data.right_count - last_right_reg;
                d_left_reg  <= in_data.left_count - last_left_reg;
                d_back_reg  <= in_data.back_count - last_back_reg;
                mag_reg     <= mag;
                turn_reg    <= mag > {1'b0, thr_reg};
                mid_reg     <= (mag > {1'b0, thr_reg}) ? mid_turn
                                                        : {in_data.heading, 16'd0};
            end
            OP_MUL_R:
            begin
                p_reg <= mul_p;
            end
            OP_MUL_L:
            begin
                right_in_reg <= inch;
                p_reg        <= mul_p;
            end
            OP_MUL_B:
            begin
                left_in_reg <= inch;
                p_reg       <= mul_p;
            end
            OP_DEC:
            begin
                back_in_reg <= inch;
                lx_reg      <= {{(V_W-INCH_W){inch[INCH_W-1]}}, inch};
                ly_reg      <= {{(V_W-INCH_W){left_in_reg[INCH_W-1]}}, left_in_reg};
            end
            OP_ROT_INIT:
            begin
                cx_reg <= rx;
                cy_reg <= ry;
                cz_reg <= rz;
            end
            OP_ROT_STEP:
            begin
                if (!cz_reg[Z_W-1]) begin
                    cx_reg <= cx_reg - sy;
                    cy_reg <= cy_reg + sx;
                    cz_reg <= cz_reg - atan_z;
                end else begin
                    cx_reg <= cx_reg + sy;
                    cy_reg <= cy_reg - sx;
                    cz_reg <= cz_reg + atan_z;
                end
            end
            OP_Q_ABS:
            begin
                qneg_reg <= q_src[V_W-1];
                qm_reg   <= q_abs[V_W-2:0];
            end
            OP_Q_HI:
            begin
                p_reg <= mul_p;
            end
            OP_Q_LO:
            begin
                qhi_reg <= p_reg[55:0];
                p_reg   <= mul_p;
            end
            OP_Q_END:
            begin
                case (cmd.phase)
                    PH_ARC:   s_reg  <= q_mag[31:0];
                    PH_KB:    lx_reg <= q_res;
                    PH_KR:    ly_reg <= q_res;
                    PH_FIN_X: ly_reg <= q_res;
                    PH_FIN_Y: lx_reg <= q_res;
                    default:  ;
                endcase
            end
            OP_H_MUL:
            begin
                p_reg <= mul_p;
            end
            OP_H_END:
            begin
                h_reg <= h_sum[47:16];
            end
            OP_DIV_INIT:
            begin
                sat_reg <= div_num[62:31] >= h_reg;
                rem_reg <= div_num[62:31];
                num_reg <= div_num[30:0];
                quo_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                num_reg <= {num_reg[DIV_STEPS-2:0], 1'b0};
                if (div_trial >= {1'b0, h_reg}) begin
                    rem_reg <= 32'(div_trial - {1'b0, h_reg});
                    quo_reg <= {quo_reg[DIV_STEPS-2:0], 1'b1};
                end else begin
                    rem_reg <= div_trial[31:0];
                    quo_reg <= {quo_reg[DIV_STEPS-2:0], 1'b0};
                end
            end
            OP_K:
            begin
                if (sat_reg || ({1'b0, quo_reg} > ONE_Q30)) begin
                    k_reg <= ONE_Q30;
                end else begin
                    k_reg <= {1'b0, quo_reg};
                end
            end
            default: ;
        endcase
    end

    assign stat.turn      = turn_reg;
    assign out_data.x_pos = x_accum_reg;
    assign out_data.y_pos = y_accum_reg;

endmodule

`default_nettype wire

@@ rtl/aopi_ctrl.sv @@
`default_nettype none

`include "assert_macros.svh"

module aopi_ctrl #(
    parameter int CORDIC_STEPS = aopi_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    input  wire aopi_pkg::aopi_stat_t stat,
    output aopi_pkg::aopi_cmd_t       cmd
);
    import aopi_pkg::*;

    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic              acc_fire;

    // the pose may only advance once the previous result has left
    assign acc_fire = (state_reg == ST_ACC) && (!out_valid_reg || !out_stall);

    // next state
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_MUL_R;
            ST_MUL_R:    state_next = ST_MUL_L;
            ST_MUL_L:    state_next = ST_MUL_B;
            ST_MUL_B:    state_next = ST_DEC;
            ST_DEC:
            begin
                phase_next = stat.turn ? PH_ARC : PH_FIN_X;
                state_next = ST_ROT_INIT;
            end
            ST_ROT_INIT:
            begin
                step_next  = '0;
                state_next = ST_ROT_STEP;
            end
            ST_ROT_STEP:
            begin
                if (step_reg == STEP_W'(CORDIC_STEPS - 1)) begin
                    state_next = ST_Q_ABS;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_Q_ABS:    state_next = ST_Q_HI;
            ST_Q_HI:     state_next = ST_Q_LO;
            ST_Q_LO:     state_next = ST_Q_END;
            ST_Q_END:
            begin
                unique case (phase_reg)
                    PH_ARC:   state_next = ST_H_MUL;
                    PH_KB:
                    begin
                        phase_next = PH_KR;
                        state_next = ST_Q_ABS;
                    end
                    PH_KR:
                    begin
                        phase_next = PH_FIN_X;
                        state_next = ST_ROT_INIT;
                    end
                    PH_FIN_X:
                    begin
                        phase_next = PH_FIN_Y;
                        state_next = ST_Q_ABS;
                    end
                    PH_FIN_Y: state_next = ST_ACC;
                    default:  state_next = ST_IDLE;
                endcase
            end
            ST_H_MUL:    state_next = ST_H_END;
            ST_H_END:    state_next = ST_DIV_INIT;
            ST_DIV_INIT:
            begin
                step_next  = '0;
                state_next = ST_DIV_STEP;
            end
            ST_DIV_STEP:
            begin
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    state_next = ST_K;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_K:
            begin
                phase_next = PH_KB;
                state_next = ST_Q_ABS;
            end
            ST_ACC:      if (acc_fire) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // commands and handshake outputs
    always_comb
    begin
        cmd.phase = phase_reg;
        cmd.step  = step_reg;
        unique case (state_reg)
            ST_IDLE:     cmd.op = in_valid ? OP_LOAD : OP_NONE;
            ST_MUL_R:    cmd.op = OP_MUL_R;
            ST_MUL_L:    cmd.op = OP_MUL_L;
            ST_MUL_B:    cmd.op = OP_MUL_B;
            ST_DEC:      cmd.op = OP_DEC;
            ST_ROT_INIT: cmd.op = OP_ROT_INIT;
            ST_ROT_STEP: cmd.op = OP_ROT_STEP;
            ST_Q_ABS:    cmd.op = OP_Q_ABS;
            ST_Q_HI:     cmd.op = OP_Q_HI;
            ST_Q_LO:     cmd.op = OP_Q_LO;
            ST_Q_END:    cmd.op = OP_Q_END;
            ST_H_MUL:    cmd.op = OP_H_MUL;
            ST_H_END:    cmd.op = OP_H_END;
            ST_DIV_INIT: cmd.op = OP_DIV_INIT;
            ST_DIV_STEP: cmd.op = OP_DIV_STEP;
            ST_K:        cmd.op = OP_K;
            ST_ACC:      cmd.op = acc_fire ? OP_ACC : OP_NONE;
            default:     cmd.op = OP_NONE;
        endcase
        in_stall = (state_reg != ST_IDLE);
    end

    // hold the result until taken, raise it when the pose advances
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (acc_fire) begin
            out_valid_next = 1'b1;
        end else if (out_valid_reg && !out_stall) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_ARC;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state_reg == ST_MUL_R, "accepted request did not start")
    `ASSERT_IMPLY(a_result_from_acc, $rose(out_valid_reg), $past(state_reg) == ST_ACC, "result raised outside accumulate")
    `ASSERT_IMPLY(a_rot_step_bound, state_reg == ST_ROT_STEP, step_reg < STEP_W'(CORDIC_STEPS), "rotation step past the end")
    `ASSERT_IMPLY(a_div_step_bound, state_reg == ST_DIV_STEP, step_reg < STEP_W'(DIV_STEPS), "division step past the end")

endmodule

`default_nettype wire

@@ rtl/arc_odometry_pose_integrator.sv @@
// Channel  Direction  Payload     Handshake
// in       sink       aopi_in_t   in_valid / in_stall
// out      source     aopi_out_t  out_valid / out_stall
// cfg      sink       index+data  cfg_we, no wait
//
// A sample is worked through in sequence by the iterative rotator, the 31-step
// restoring divider and the shared multiplier; a turn adds an arc rotation, the
// division and the scaling of both legs to the final rotation that every move runs.
// A new sample is taken only in idle; a finished result waits in the output
// register while the next sample runs, and the pose update waits for it to go.
// Reset clears the encoder history, heading and pose and loads default scales.
`default_nettype none

module arc_odometry_pose_integrator #(
    parameter int CORDIC_STEPS = aopi_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [aopi_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [aopi_pkg::CFG_W-1:0] cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire aopi_pkg::aopi_in_t         in_data,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output aopi_pkg::aopi_out_t             out_data
);
    import aopi_pkg::*;

    aopi_cmd_t  cmd;
    aopi_stat_t stat;

    // sequence the work
    aopi_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // arithmetic and pose state
    aopi_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

@@ bench/arc_odometry_pose_integrator_tb.sv @@
`timescale 1ns / 1ps
`default_nettype none

module arc_odometry_pose_integrator_tb;
    import aopi_pkg::*;

    localparam int          ROT_STEPS   = 16;
    localparam int          CYCLE_LIMIT = 3000000;
    localparam int          DRAIN_WAIT  = 120;
    localparam logic [1:0]  REG_UNUSED  = 2'd3;
    localparam longint      POSE_MAX    = 64'sd140737488355327;
    localparam longint      POSE_MIN    = -64'sd140737488355328;

    // arctangent of 2^-i, 2^32 units per turn
    localparam logic [31:0] ARCTAN [0:23] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    logic              in_valid;
    logic              in_stall;
    aopi_in_t          in_data;
    logic              out_valid;
    logic              out_stall;
    aopi_out_t         out_data;

    arc_odometry_pose_integrator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // pose model state
    logic [23:0] drive_scale, back_scale;
    logic [14:0] straight_limit;
    logic [31:0] prev_right, prev_left, prev_back;
    logic [15:0] prev_heading;
    longint      pose_x, pose_y;

    aopi_out_t   pose_queue[$];
    int          mismatches;
    int          send_idle_pct, recv_idle_pct;
    logic        hold_start;
    int          hold_left;
    int          cycles;

    // directed rows: a register write or a request, some with a typed answer
    typedef struct {
        logic      is_write;
        logic [1:0] idx;
        logic [23:0] val;
        aopi_in_t  req;
        logic      typed;
        aopi_out_t want;
    } row_t;

    row_t rows[$];

    initial clk = 1'b0;

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("arc_odometry_pose_integrator_tb NOT OK");
            $finish;
        end
    end

    // floor division by 2^s
    function automatic longint floor_shr(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -((-(v + 1)) >>> s) - 1;
    endfunction

    // v * c / 2^30, rounded half away from zero
    function automatic longint q30_mul(longint v, longint unsigned c);
        logic neg;
        longint unsigned m, r;
        neg = v < 0;
        m = neg ? longint'(unsigned'(-(v + 1))) + 64'd1 : longint'(unsigned'(v));
        r = (m >> 30) * c + (((m & 64'h3FFFFFFF) * c + (64'd1 << 29)) >> 30);
        return neg ? -longint'(r) : longint'(r);
    endfunction

    // rotate (p, q) by a 32-bit binary angle, gain removed
    task automatic rotate_vec(inout longint p, inout longint q, input logic [31:0] ang);
        longint x, y, z, dx, dy;
        x = p;
        y = q;
        z = longint'($signed(ang));
        if (z > 64'sh40000000) begin
            x = -x; y = -y; z -= 64'sh80000000;
        end else if (z < -64'sh40000000) begin
            x = -x; y = -y; z += 64'sh80000000;
        end
        for (int i = 0; i < ROT_STEPS; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ARCTAN[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ARCTAN[i]);
            end
        end
        p = q30_mul(x, GAIN_Q30);
        q = q30_mul(y, GAIN_Q30);
    endtask

    function automatic longint ticks_to_inches(logic [31:0] cur, logic [31:0] last,
                                               logic [23:0] scale);
        logic [31:0] diff;
        longint d;
        diff = cur - last;
        d = longint'($signed(diff));
        return floor_shr(d * longint'({40'd0, scale}) + 128, 8);
    endfunction

    function automatic longint clamp_pose(longint v);
        if (v > POSE_MAX) return POSE_MAX;
        if (v < POSE_MIN) return POSE_MIN;
        return v;
    endfunction

    function automatic void apply_write(logic [1:0] idx, logic [23:0] val);
        if (idx == REG_DRIVE)
            drive_scale = val;
        else if (idx == REG_BACK)
            back_scale = val;
        else if (idx == REG_THRESH)
            straight_limit = val[14:0];
    endfunction

    // advance the pose by one sample and return the new pose
    task automatic integrate_sample(input aopi_in_t s, output aopi_out_t res);
        longint right_in, left_in, back_in, lx, ly, c, sn;
        longint unsigned h, k;
        logic [15:0] dd;
        logic [31:0] mid, half;
        int dh, mag;
        right_in = ticks_to_inches(s.right_count, prev_right, drive_scale);
        left_in  = ticks_to_inches(s.left_count, prev_left, drive_scale);
        back_in  = ticks_to_inches(s.back_count, prev_back, back_scale);
        dd = s.heading - prev_heading;
        dh = int'($signed(dd));
        mag = dh < 0 ? -dh : dh;
        prev_right = s.right_count;
        prev_left = s.left_count;
        prev_back = s.back_count;
        prev_heading = s.heading;
        if (mag <= int'(straight_limit)) begin
            lx = back_in;
            ly = left_in;
            mid = {s.heading, 16'd0};
        end else begin
            c = 64'sd1 << 30;
            sn = 0;
            half = 32'(mag) << 15;
            rotate_vec(c, sn, half);
            if (sn < 0)
                sn = -sn;
            h = (longint'(unsigned'(mag)) * PI_Q30 + 64'd32768) >> 16;
            k = ((longint'(unsigned'(sn)) << 30) + (h >> 1)) / h;
            if (k > (64'd1 << 30))
                k = 64'd1 << 30;
            lx = q30_mul(back_in, k);
            ly = q30_mul(right_in, k);
            mid = dh < 0 ? {s.heading, 16'd0} + half : {s.heading, 16'd0} - half;
        end
        rotate_vec(ly, lx, mid);
        pose_y = clamp_pose(pose_y + ly);
        pose_x = clamp_pose(pose_x + lx);
        res.x_pos = pose_x[47:0];
        res.y_pos = pose_y[47:0];
    endtask

    // check each delivered pose against the oldest prediction
    always @(posedge clk) begin
        aopi_out_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pose_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pose x=%0d y=%0d",
                             out_data.x_pos, out_data.y_pos);
            end else begin
                want = pose_queue.pop_front();
                if (out_data.x_pos !== want.x_pos ||
                    out_data.y_pos !== want.y_pos) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pose mismatch: want x=%0d y=%0d got x=%0d y=%0d",
                                 want.x_pos, want.y_pos,
                                 out_data.x_pos, out_data.y_pos);
                end
            end
        end
    end

    // receiver: random stall plus a long hold-off on request
    always @(posedge clk) begin
        if (hold_start)
            hold_left <= 400;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
        out_stall <= hold_start || hold_left > 1 ||
                     ($urandom_range(99) < recv_idle_pct);
    end

    task automatic send_request(input aopi_in_t s, input logic typed, input aopi_out_t want);
        aopi_out_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= s;
        do @(posedge clk); while (in_stall);
        integrate_sample(s, res);
        if (typed && (res !== want)) begin
            mismatches++;
            if (mismatches <= 10)
                $display("typed answer disagrees: want x=%0d y=%0d model x=%0d y=%0d",
                         want.x_pos, want.y_pos, res.x_pos, res.y_pos);
        end
        pose_queue.push_back(typed ? want : res);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pose_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // one write strobe, then the port is left quiet before anything else drives it
    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        apply_write(idx, val);
        @(posedge clk);
    endtask

    function automatic logic [23:0] pick_scale();
        case ($urandom_range(3))
            0: return 24'hFFFFFF;
            1: return 24'd1 + 24'($urandom_range(15));
            default: return 24'($urandom);
        endcase
    endfunction

    // next random sample: mostly small moves, some noise
    function automatic aopi_in_t next_sample();
        aopi_in_t s;
        int pick;
        pick = $urandom_range(99);
        if (pick < 12) begin
            s = {$urandom, $urandom, $urandom, 16'($urandom)};
            return s;
        end
        s.right_count = prev_right + 32'($signed($urandom_range(4000)) - 2000);
        s.left_count  = prev_left + 32'($signed($urandom_range(4000)) - 2000);
        s.back_count  = prev_back + 32'($signed($urandom_range(40000)) - 20000);
        if (pick < 18)
            s.right_count = prev_right + $urandom;
        case ($urandom_range(3))
            0: s.heading = prev_heading + 16'($urandom_range(int'(straight_limit)));
            1: s.heading = prev_heading - 16'($urandom_range(int'(straight_limit)));
            2: s.heading = prev_heading + 16'($signed($urandom_range(8000)) - 4000);
            default: s.heading = 16'($urandom);
        endcase
        return s;
    endfunction

    function automatic row_t req_row(logic [31:0] r, logic [31:0] l, logic [31:0] b,
                                     logic [15:0] hd);
        row_t w;
        w = '{default: '0};
        w.req = {r, l, b, hd};
        return w;
    endfunction

    function automatic row_t wr_row(logic [1:0] idx, logic [23:0] val);
        row_t w;
        w = '{default: '0};
        w.is_write = 1'b1;
        w.idx = idx;
        w.val = val;
        return w;
    endfunction

    task automatic run_random(input int count, input int cfg_every);
        aopi_out_t none;
        none = '0;
        for (int n = 0; n < count; n++) begin
            if (cfg_every > 0 && n > 0 && n % cfg_every == 0) begin
                wait_drained();
                write_reg(REG_DRIVE, pick_scale());
                write_reg(REG_BACK, pick_scale());
                write_reg(REG_THRESH, ($urandom_range(3) == 0) ? 24'($urandom)
                                      : 24'($urandom_range(2000)));
            end
            send_request(next_sample(), 1'b0, none);
        end
    endtask

    initial begin
        row_t w;
        cycles = 0;
        mismatches = 0;
        send_idle_pct = 20;
        recv_idle_pct = 76;
        hold_start = 1'b0;
        hold_left = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        drive_scale = DRIVE_RST;
        back_scale = BACK_RST;
        straight_limit = THRESH_RST;
        prev_right = '0;
        prev_left = '0;
        prev_back = '0;
        prev_heading = '0;
        pose_x = 0;
        pose_y = 0;

        // first sample after reset: no motion gives the origin
        w = req_row(0, 0, 0, 0);
        w.typed = 1'b1;
        rows.push_back(w);
        // zero scales: no motion whatever the counts
        rows.push_back(wr_row(REG_DRIVE, 24'd0));
        rows.push_back(wr_row(REG_BACK, 24'd0));
        w = req_row(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 16'd0);
        w.typed = 1'b1;
        rows.push_back(w);
        rows.push_back(wr_row(REG_DRIVE, DRIVE_RST));
        rows.push_back(wr_row(REG_BACK, BACK_RST));
        rows.push_back(wr_row(REG_UNUSED, 24'hFFFFFF));
        // straight moves, count wrap, heading wrap across zero
        rows.push_back(req_row(32'h7FFFFF00, 32'h7FFFFF00, 32'h7FFFF000, 16'd100));
        rows.push_back(req_row(32'h80000100, 32'h80000100, 32'h80001000, 16'd65500));
        rows.push_back(req_row(32'h80000200, 32'h80000300, 32'h80000000, 16'd10));
        // turns: largest positive and negative heading steps
        rows.push_back(req_row(32'h80001200, 32'h80001300, 32'h80000100, 16'd32777));
        rows.push_back(req_row(32'h80002200, 32'h80002000, 32'h80000000, 16'd9));
        rows.push_back(req_row(32'h80002300, 32'h80002100, 32'h80000200, 16'd16384));
        // turn just over the straight limit
        rows.push_back(req_row(32'h80002400, 32'h80002100, 32'h80000200, 16'd16567));
        // threshold extremes, with a value wider than the register
        rows.push_back(wr_row(REG_THRESH, 24'd0));
        rows.push_back(req_row(32'h80002500, 32'h80002200, 32'h80000300, 16'd16568));
        rows.push_back(wr_row(REG_THRESH, 24'hFF4000));
        rows.push_back(req_row(32'h80003500, 32'h80002200, 32'h80000300, 16'd200));
        // largest scales: drive the accumulators into saturation
        rows.push_back(wr_row(REG_DRIVE, 24'hFFFFFF));
        rows.push_back(wr_row(REG_BACK, 24'hFFFFFF));
        rows.push_back(req_row(32'h0, 32'h0, 32'h0, 16'd200));
        rows.push_back(req_row(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'd200));
        rows.push_back(req_row(32'hFFFFFFFE, 32'hFFFFFFFE, 32'hFFFFFFFE, 16'd200));
        rows.push_back(req_row(32'h7FFFFFFD, 32'h7FFFFFFD, 32'h7FFFFFFD, 16'd200));
        rows.push_back(req_row(32'h7FFFFFFD, 32'h7FFFFFFD, 32'h7FFFFFFD, 16'd32968));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        foreach (rows[i]) begin
            if (rows[i].is_write) begin
                wait_drained();
                write_reg(rows[i].idx, rows[i].val);
            end else begin
                send_request(rows[i].req, rows[i].typed, rows[i].want);
            end
        end

        // sender idles less than the receiver
        wait_drained();
        write_reg(REG_DRIVE, DRIVE_RST);
        write_reg(REG_BACK, BACK_RST);
        write_reg(REG_THRESH, {9'd0, THRESH_RST});
        run_random(340, 0);

        // receiver idles less, extreme settings
        wait_drained();
        send_idle_pct = 76;
        recv_idle_pct = 20;
        write_reg(REG_DRIVE, 24'd1);
        write_reg(REG_BACK, 24'hFFFFFF);
        write_reg(REG_THRESH, 24'd16384);
        run_random(340, 0);

        // no idling: long receiver hold-off while requests keep coming
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_THRESH, 24'd0);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        run_random(40, 0);
        // pause the sender until every pose is back
        in_valid <= 1'b0;
        @(posedge clk);
        while (pose_queue.size() != 0)
            @(posedge clk);
        run_random(330, 60);

        wait_drained();
        if (mismatches == 0)
            $display("arc_odometry_pose_integrator_tb OK");
        else
            $display("arc_odometry_pose_integrator_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

@@ arc_odometry_pose_integrator.f @@
+incdir+rtl
rtl/aopi_pkg.sv
rtl/aopi_datapath.sv
rtl/aopi_ctrl.sv
rtl/arc_odometry_pose_integrator.sv
bench/arc_odometry_pose_integrator_tb.sv
